### hw/rtl/dpt_pkg.sv
// Shared types, constants and lookup functions of the DNA to protein translator.
package dpt_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegReverseStrand   = 2'd0;
  localparam logic [1:0] RegWholeGenomeMode = 2'd1;

  localparam int MaxCodons = 65536;
  localparam logic [15:0] CodonCap =
    ((MaxCodons - 1) > 65535) ? 16'hFFFF : 16'(MaxCodons - 1);

  localparam int          CodonEntries = 65;
  localparam logic [6:0]  UnknownCode  = 7'd64;
  localparam logic [2:0]  BaseUnknown  = 3'd4;

  // Codon codes of the alternative start codons.
  localparam logic [6:0]  CodeGtg = 7'd46;
  localparam logic [6:0]  CodeTtg = 7'd62;
  localparam logic [6:0]  CodeCaa = 7'd16;
  localparam logic [6:0]  CodeCac = 7'd17;

  localparam logic [7:0]  AsciiStop = 8'h2A;
  localparam logic [7:0]  AsciiMet  = 8'h4D;
  localparam logic [7:0]  AsciiX    = 8'h58;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Character 0 of each string sits in the top byte.
  localparam logic [8*CodonEntries-1:0] FwdTable =
    "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLFX";
  localparam logic [8*CodonEntries-1:0] RevTable =
    "FVLICGRSSAPTYDHNLVLMWGRRSAPT*EQKFVLICGRSSAPTYDHNLVLI*GRRSAPT*EQKX";

  typedef struct packed {
    logic [7:0]  amino_acid;
    logic [15:0] codon_number;
    logic        last_result;
  } dpt_result_t;

  // Up to two results caused by one character; slot0 is always valid.
  typedef struct packed {
    logic        slot1_valid;
    dpt_result_t slot0;
    dpt_result_t slot1;
  } dpt_entry_t;

  function automatic logic [2:0] decode_base(logic [7:0] ch);
    logic [2:0] d;
    unique case (ch)
      8'h41, 8'h61: d = 3'd0;
      8'h43, 8'h63: d = 3'd1;
      8'h47, 8'h67: d = 3'd2;
      8'h54, 8'h74: d = 3'd3;
      default:      d = BaseUnknown;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] lookup_amino(logic [6:0] code, logic rev);
    logic [7:0] aa;
    if (code > UnknownCode) begin
      aa = AsciiX;
    end else if (rev) begin
      aa = RevTable[8*(CodonEntries - 1 - int'(code)) +: 8];
    end else begin
      aa = FwdTable[8*(CodonEntries - 1 - int'(code)) +: 8];
    end
    return aa;
  endfunction

endpackage

### hw/rtl/dpt_channels.sv
// Handshake channel interfaces of the translator: characters, results and register writes.
interface dpt_in_if;
  import dpt_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] nucleotide;
  logic       last_char;
  modport source (output valid, nucleotide, last_char, input ready);
  modport sink (input valid, nucleotide, last_char, output ready);
endinterface

interface dpt_out_if;
  import dpt_pkg::*;
  logic        valid;
  logic        ready;
  logic [7:0]  amino_acid;
  logic [15:0] codon_number;
  logic        last_result;
  modport source (output valid, amino_acid, codon_number, last_result, input ready);
  modport sink (input valid, amino_acid, codon_number, last_result, output ready);
endinterface

interface dpt_cfg_if;
  import dpt_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/dpt_front.sv
// Front end: holds the configuration, assembles codons and forms the results of each character.
module dpt_front
  import dpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dpt_in_if.sink      in_chan,
  dpt_cfg_if.sink     cfg_chan,
  input  logic        queue_full,
  output logic        push,
  output dpt_entry_t  push_entry
);

  logic        reverse_r, genome_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [6:0]  pidx_r, pidx_nxt;
  logic [7:0]  held_amino_r, held_amino_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic [15:0] held_number_r, held_number_nxt;
  logic [15:0] count_r, count_nxt;

  logic        accept;
  logic        fin;
  logic [2:0]  dec;
  logic [6:0]  code;
  logic [7:0]  aa;
  logic        drop;
  logic        e0_valid;
  dpt_result_t e0, fres;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !queue_full;
  assign accept         = in_chan.valid && in_chan.ready;
  assign fin            = in_chan.last_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r <= 1'b0;
      genome_r  <= 1'b0;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == RegReverseStrand) begin
        reverse_r <= cfg_chan.data;
      end else if (cfg_chan.index == RegWholeGenomeMode) begin
        genome_r <= cfg_chan.data;
      end
    end
  end

  always_comb begin
    dec = decode_base(in_chan.nucleotide);
    if (phase_r == 2'd0) begin
      code = (dec == BaseUnknown) ? UnknownCode : {4'd0, dec};
    end else begin
      code = (pidx_r >= UnknownCode || dec == BaseUnknown) ? UnknownCode
                                                          : {pidx_r[4:0], dec[1:0]};
    end

    aa = lookup_amino(code, reverse_r);
    if (genome_r) begin
      if (!reverse_r && count_r == 16'd0 && (code == CodeGtg || code == CodeTtg)) begin
        aa = AsciiMet;
      end
      if (reverse_r && fin && (code == CodeCaa || code == CodeCac)) begin
        aa = AsciiMet;
      end
    end
    drop = (aa == AsciiStop) && ((!reverse_r && fin) || (reverse_r && count_r == 16'd0));

    phase_nxt       = phase_r;
    pidx_nxt        = pidx_r;
    count_nxt       = count_r;
    held_amino_nxt  = held_amino_r;
    held_number_nxt = held_number_r;
    held_valid_nxt  = held_valid_r;
    e0_valid        = 1'b0;
    e0              = '{amino_acid: held_amino_r, codon_number: held_number_r,
                        last_result: 1'b0};

    if (phase_r == 2'd2) begin
      if (!drop) begin
        e0_valid        = held_valid_r;
        held_amino_nxt  = aa;
        held_number_nxt = count_r;
        held_valid_nxt  = 1'b1;
      end
      if (count_r < CodonCap) begin
        count_nxt = count_r + 16'd1;
      end
      phase_nxt = 2'd0;
      pidx_nxt  = 7'd0;
    end else begin
      phase_nxt = phase_r + 2'd1;
      pidx_nxt  = code;
    end

    fres = '{amino_acid: held_amino_nxt, codon_number: held_number_nxt,
             last_result: 1'b1};
    if (fin) begin
      // A partial codon at the end of a forward strand still yields an unknown residue.
      if (phase_nxt != 2'd0 && !reverse_r) begin
        e0_valid        = held_valid_nxt;
        e0              = '{amino_acid: held_amino_nxt, codon_number: held_number_nxt,
                            last_result: 1'b0};
        held_valid_nxt  = 1'b1;
        fres            = '{amino_acid: AsciiX, codon_number: count_nxt,
                            last_result: 1'b1};
      end
    end

    if (e0_valid) begin
      push_entry.slot0       = e0;
      push_entry.slot1       = fres;
      push_entry.slot1_valid = fin && held_valid_nxt;
    end else begin
      push_entry.slot0       = fres;
      push_entry.slot1       = fres;
      push_entry.slot1_valid = 1'b0;
    end
    push = accept && (e0_valid || (fin && held_valid_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= 2'd0;
      pidx_r        <= 7'd0;
      held_amino_r  <= 8'd0;
      held_valid_r  <= 1'b0;
      held_number_r <= 16'd0;
      count_r       <= 16'd0;
    end else if (accept) begin
      if (fin) begin
        phase_r       <= 2'd0;
        pidx_r        <= 7'd0;
        held_amino_r  <= 8'd0;
        held_valid_r  <= 1'b0;
        held_number_r <= 16'd0;
        count_r       <= 16'd0;
      end else begin
        phase_r       <= phase_nxt;
        pidx_r        <= pidx_nxt;
        held_amino_r  <= held_amino_nxt;
        held_valid_r  <= held_valid_nxt;
        held_number_r <= held_number_nxt;
        count_r       <= count_nxt;
      end
    end
  end

endmodule

### hw/rtl/dpt_queue.sv
// Short entry queue between the front end and the output stage.
module dpt_queue
  import dpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dpt_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output dpt_entry_t head
);

  dpt_entry_t             mem_r [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QueueCntW-1:0]   count_r;
  logic                   do_push, do_pop;

  assign full      = (count_r == QueueCntW'(QueueDepth));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QueueCntW'(1);
      end
    end
  end

endmodule

### hw/rtl/dpt_back.sv
// Output stage: drains queue entries one result at a time into the output register.
module dpt_back
  import dpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       not_empty,
  input  dpt_entry_t head,
  output logic       pop,
  dpt_out_if.source  out_chan
);

  logic        out_valid_r;
  dpt_result_t out_item_r;
  logic        second_valid_r;
  dpt_result_t second_item_r;
  logic        load;

  assign load = !out_valid_r || out_chan.ready;
  assign pop  = load && !second_valid_r && not_empty;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.amino_acid   = out_item_r.amino_acid;
  assign out_chan.codon_number = out_item_r.codon_number;
  assign out_chan.last_result  = out_item_r.last_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      second_valid_r <= 1'b0;
    end else if (load) begin
      if (second_valid_r) begin
        out_valid_r    <= 1'b1;
        second_valid_r <= 1'b0;
      end else begin
        out_valid_r    <= not_empty;
        second_valid_r <= not_empty && head.slot1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_valid_r) begin
        out_item_r <= second_item_r;
      end else begin
        out_item_r    <= head.slot0;
        second_item_r <= head.slot1;
      end
    end
  end

endmodule

### hw/rtl/dna_to_protein_translator.sv
// Top level of the DNA to protein translator.
//
// Characters arrive on in_chan, one per transfer, with last_char on the final
// one. Every third character closes a codon, which is translated with the
// forward or the reverse strand table; amino acids leave on out_chan with their
// codon number and a last_result flag on the final one. One residue is held
// until the next codon or the end of the sequence, so a result appears once the
// following codon (or last_char) has been taken; it then passes through the queue
// and the output register to out_chan. A character is taken every cycle while the
// four-entry queue between the front end and the output stage has room; the
// output stage delivers one result per cycle while the receiver is ready, and
// a second result holds back the next queue entry. When the receiver stalls, the
// output register holds, the queue fills, and in_chan.ready drops once it is full.
// cfg_chan writes the strand and whole-genome registers, one per transfer, and
// is always ready; write it only while no sequence is in flight.
// Reset (synchronous, rst_n low) clears the registers, the codon state and
// the queue; the block is ready for characters as soon as reset is released.
module dna_to_protein_translator
  import dpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dpt_in_if.sink     in_chan,
  dpt_out_if.source  out_chan,
  dpt_cfg_if.sink    cfg_chan
);

  logic       push, full, pop, not_empty;
  dpt_entry_t push_entry, head;

  dpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .queue_full (full),
    .push       (push),
    .push_entry (push_entry)
  );

  dpt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  dpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule
